[design/cartesian_to_polar_assert.svh]
// ----------------------------------------------------------------------------
// cartesian_to_polar_assert.svh
// Assertion macros used by the cartesian_to_polar top-level design file.
// ----------------------------------------------------------------------------
`ifndef CARTESIAN_TO_POLAR_ASSERT_SVH
`define CARTESIAN_TO_POLAR_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define C2P_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cartesian_to_polar: check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define C2P_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cartesian_to_polar: check failed");

`endif

[design/c2p_pkg.sv]
// ----------------------------------------------------------------------------
// c2p_pkg
// Types and constants of the rectangular to polar CORDIC pipeline.
// ----------------------------------------------------------------------------
package c2p_pkg;

  localparam int FRAC_BITS = 14;
  localparam int ATAN_LEN  = 24;
  localparam int ANGLE_W   = 16;
  localparam int RADIUS_W  = 21;
  localparam int TURN_W    = 32;
  localparam int GAIN_W    = 30;
  localparam int PROD_W    = 62;

  localparam logic [GAIN_W-1:0]   GAIN_Q30   = 30'd652032874;
  localparam logic [RADIUS_W-1:0] RADIUS_MAX = 21'h1FFFFF;
  localparam logic [TURN_W-1:0]   TURN_HALF  = 32'h8000_0000;
  localparam logic [TURN_W-1:0]   ANGLE_RND  = 32'h0000_8000;
  localparam logic [PROD_W-1:0]   RADIUS_RND = 62'h80_0000_0000;

  localparam logic [TURN_W-1:0] ATAN_TURNS [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic              zero;
    logic [TURN_W-1:0] z;
  } c2p_side_t;

endpackage

[design/c2p_prerot.sv]
// ----------------------------------------------------------------------------
// c2p_prerot
// Input stage: flags the zero vector, turns the left half plane by a half
// turn and scales the coordinates to the fixed-point datapath format.
// ----------------------------------------------------------------------------
module c2p_prerot
  import c2p_pkg::*;
#(
  parameter int COORD_BITS = 17,
  parameter int DW         = 33
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic signed [COORD_BITS-1:0] vec_x_i,
  input  logic signed [COORD_BITS-1:0] vec_y_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic signed [DW-1:0]         x_o,
  output logic signed [DW-1:0]         y_o,
  output c2p_side_t                    side_o
);

  logic                 valid_q;
  logic signed [DW-1:0] xe, ye, xr, yr;
  logic signed [DW-1:0] x_d, y_d, x_q, y_q;
  c2p_side_t            side_d, side_q;

  assign xe = {{(DW-COORD_BITS){vec_x_i[COORD_BITS-1]}}, vec_x_i};
  assign ye = {{(DW-COORD_BITS){vec_y_i[COORD_BITS-1]}}, vec_y_i};

  always_comb begin
    side_d.zero = (vec_x_i == '0) && (vec_y_i == '0);
    if (vec_x_i[COORD_BITS-1]) begin
      xr       = -xe;
      yr       = -ye;
      side_d.z = TURN_HALF;
    end else begin
      xr       = xe;
      yr       = ye;
      side_d.z = '0;
    end
    x_d = xr <<< FRAC_BITS;
    y_d = yr <<< FRAC_BITS;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign side_o  = side_q;

endmodule

[design/c2p_stage.sv]
// ----------------------------------------------------------------------------
// c2p_stage
// One registered CORDIC vectoring micro-rotation by atan(2^-STAGE).
// ----------------------------------------------------------------------------
module c2p_stage
  import c2p_pkg::*;
#(
  parameter int DW    = 33,
  parameter int STAGE = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [DW-1:0] x_i,
  input  logic signed [DW-1:0] y_i,
  input  c2p_side_t            side_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic signed [DW-1:0] x_o,
  output logic signed [DW-1:0] y_o,
  output c2p_side_t            side_o
);

  logic                 valid_q;
  logic signed [DW-1:0] xs, ys, x_d, y_d, x_q, y_q;
  c2p_side_t            side_d, side_q;

  assign xs = x_i >>> STAGE;
  assign ys = y_i >>> STAGE;

  always_comb begin
    side_d.zero = side_i.zero;
    if (!y_i[DW-1]) begin
      x_d      = x_i + ys;
      y_d      = y_i - xs;
      side_d.z = side_i.z + ATAN_TURNS[STAGE];
    end else begin
      x_d      = x_i - ys;
      y_d      = y_i + xs;
      side_d.z = side_i.z - ATAN_TURNS[STAGE];
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign side_o  = side_q;

endmodule

[design/c2p_post.sv]
// ----------------------------------------------------------------------------
// c2p_post
// Output stages: gain correction multiply, then rounding, saturation and the
// minimum radius test into the output register.
// ----------------------------------------------------------------------------
module c2p_post
  import c2p_pkg::*;
#(
  parameter int DW = 33
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [DW-1:0] x_i,
  input  c2p_side_t            side_i,
  input  logic [RADIUS_W-1:0]  min_radius_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [RADIUS_W-1:0]  radius_o,
  output logic [ANGLE_W-1:0]   angle_o,
  output logic                 is_point_o
);

  logic                      va_q, vb_q, ready_a;
  logic [TURN_W-1:0]         x_lo;
  logic                      sat_d, sat_q, zero_q;
  logic [PROD_W-1:0]         prod_d, prod_q, rsum;
  logic [TURN_W-1:0]         zr;
  logic [ANGLE_W-1:0]        ang_q;
  logic [RADIUS_W:0]         rad_full;
  logic [RADIUS_W-1:0]       rad;
  logic                      point;
  logic [RADIUS_W-1:0]       radius_d, radius_q;
  logic [ANGLE_W-1:0]        angle_d, angle_q;
  logic                      is_point_d, is_point_q;

  if (DW > TURN_W) begin : g_wide
    assign sat_d = |x_i[DW-1:TURN_W];
    assign x_lo  = x_i[TURN_W-1:0];
  end else if (DW == TURN_W) begin : g_even
    assign sat_d = 1'b0;
    assign x_lo  = x_i;
  end else begin : g_narrow
    assign sat_d = 1'b0;
    assign x_lo  = {{(TURN_W-DW){1'b0}}, x_i};
  end

  assign prod_d = PROD_W'(x_lo) * PROD_W'(GAIN_Q30);
  assign zr     = side_i.z + ANGLE_RND;

  assign ready_a = !vb_q || ready_i;
  assign ready_o = !va_q || ready_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (ready_o) begin
        va_q <= valid_i;
      end
      if (ready_a) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      prod_q <= prod_d;
      sat_q  <= sat_d;
      zero_q <= side_i.zero;
      ang_q  <= zr[TURN_W-1:TURN_W-ANGLE_W];
    end
  end

  always_comb begin
    rsum     = prod_q + RADIUS_RND;
    rad_full = rsum[PROD_W-1:PROD_W-RADIUS_W-1];
    rad      = (sat_q || rad_full[RADIUS_W]) ? RADIUS_MAX : rad_full[RADIUS_W-1:0];
    point    = zero_q ? (min_radius_i != '0) : (rad < min_radius_i);
    if (zero_q || point) begin
      radius_d = '0;
      angle_d  = '0;
    end else begin
      radius_d = rad;
      angle_d  = ang_q;
    end
    is_point_d = point;
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && va_q) begin
      radius_q   <= radius_d;
      angle_q    <= angle_d;
      is_point_q <= is_point_d;
    end
  end

  assign valid_o    = vb_q;
  assign radius_o   = radius_q;
  assign angle_o    = angle_q;
  assign is_point_o = is_point_q;

endmodule

[design/cartesian_to_polar.sv]
// ----------------------------------------------------------------------------
// cartesian_to_polar
// Rectangular to polar conversion: vector length in Q4 and angle in 16-bit
// binary turns by a fully unrolled, registered CORDIC vectoring pipeline.
//
//   channel   handshake                  payload
//   input     in_valid_i / in_ready_o    vec_x_i, vec_y_i
//   output    out_valid_o / out_ready_i  radius_o, angle_o, is_point_o
//   config    min_radius_we_i            min_radius_i
//
// One beat per cycle while the output is not stalled; the path holds one
// register per micro-rotation plus input, multiply and output registers.
// Each stage holds while the stage after it is full and stalled, so empty
// stages still fill and the input keeps taking beats while a result waits.
// Reset empties the pipeline and sets min_radius to 1.0 (16).
// ----------------------------------------------------------------------------
module cartesian_to_polar
  import c2p_pkg::*;
#(
  parameter int CORDIC_STAGES = 16,
  parameter int COORD_BITS    = 17
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] vec_x_i,
  input  logic signed [COORD_BITS-1:0] vec_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [RADIUS_W-1:0]          radius_o,
  output logic [ANGLE_W-1:0]           angle_o,
  output logic                         is_point_o,
  input  logic                         min_radius_we_i,
  input  logic [RADIUS_W-1:0]          min_radius_i
);

  `include "cartesian_to_polar_assert.svh"

  localparam int DW = COORD_BITS + 16;

  logic [RADIUS_W-1:0]  min_radius_q;
  logic                 valid_s [CORDIC_STAGES+1];
  logic                 ready_s [CORDIC_STAGES+1];
  logic signed [DW-1:0] x_s     [CORDIC_STAGES+1];
  logic signed [DW-1:0] y_s     [CORDIC_STAGES+1];
  c2p_side_t            side_s  [CORDIC_STAGES+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_radius_q <= 21'd16;
    end else if (min_radius_we_i) begin
      min_radius_q <= min_radius_i;
    end
  end

  c2p_prerot #(
    .COORD_BITS (COORD_BITS),
    .DW         (DW)
  ) u_prerot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .vec_x_i (vec_x_i),
    .vec_y_i (vec_y_i),
    .valid_o (valid_s[0]),
    .ready_i (ready_s[0]),
    .x_o     (x_s[0]),
    .y_o     (y_s[0]),
    .side_o  (side_s[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    c2p_stage #(
      .DW    (DW),
      .STAGE (i)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[i]),
      .ready_o (ready_s[i]),
      .x_i     (x_s[i]),
      .y_i     (y_s[i]),
      .side_i  (side_s[i]),
      .valid_o (valid_s[i+1]),
      .ready_i (ready_s[i+1]),
      .x_o     (x_s[i+1]),
      .y_o     (y_s[i+1]),
      .side_o  (side_s[i+1])
    );
  end

  c2p_post #(
    .DW (DW)
  ) u_post (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_s[CORDIC_STAGES]),
    .ready_o      (ready_s[CORDIC_STAGES]),
    .x_i          (x_s[CORDIC_STAGES]),
    .side_i       (side_s[CORDIC_STAGES]),
    .min_radius_i (min_radius_q),
    .valid_o      (out_valid_o),
    .ready_i      (out_ready_i),
    .radius_o     (radius_o),
    .angle_o      (angle_o),
    .is_point_o   (is_point_o)
  );

  `C2P_ASSERT_NOW(a_point_zeroed, out_valid_o && is_point_o, radius_o == '0 && angle_o == '0)
  `C2P_ASSERT_NOW(a_radius_min, out_valid_o && !is_point_o, radius_o >= min_radius_q)
  `C2P_ASSERT_NOW(a_full_stall, !in_ready_o, out_valid_o && !out_ready_i)
  `C2P_ASSERT_NEXT(a_drain, out_valid_o && out_ready_i && !valid_s[CORDIC_STAGES] && in_ready_o,
    in_ready_o)

endmodule
